// ===== rtl/core/fba_pkg.sv =====
// fba_pkg: shared sizes, codes and payload types for the block allocator
// no dependencies; imported by every module of the allocator but fba_ram
`timescale 1ns / 1ps

package fba_pkg;

  // pool and queue sizes
  localparam int NBLOCKS   = 64;
  localparam int WAITERS   = 16;
  localparam int PRIO_BITS = 8;

  // derived widths
  localparam int BLK_W  = $clog2(NBLOCKS);
  localparam int CNT_W  = $clog2(NBLOCKS + 1);
  localparam int WIDX_W = $clog2(WAITERS);
  localparam int WCNT_W = $clog2(WAITERS + 1);

  // fixed field widths
  localparam int ID_W       = 4;
  localparam int PRIO_IN_W  = 8;
  localparam int BLKF_W     = 6;
  localparam int GRANT_W    = 32;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;

  // configuration register indexes and reset values
  localparam logic [CFG_IDX_W-1:0]  CFG_BLOCK_COUNT    = 1'd0;
  localparam logic [CFG_IDX_W-1:0]  CFG_MONITOR_ENABLE = 1'd1;
  localparam logic [CFG_DATA_W-1:0] BLOCK_COUNT_RST    = 7'd64;

  typedef enum logic [1:0] {
    FUNC_ALLOC   = 2'd0,
    FUNC_FREE    = 2'd1,
    FUNC_TIMEOUT = 2'd2,
    FUNC_INIT    = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_FAIL    = 3'd1,
    ST_QUEUED  = 3'd2,
    ST_FREED   = 3'd3,
    ST_HANDED  = 3'd4,
    ST_TIMEOUT = 3'd5,
    ST_NOTWAIT = 3'd6,
    ST_QFULL   = 3'd7
  } status_t;

  typedef struct packed {
    func_t                func;
    logic [BLKF_W-1:0]    block;
    logic [ID_W-1:0]      requester;
    logic [PRIO_IN_W-1:0] priority_req;
    logic                 wait_allowed;
  } in_req_t;

  typedef struct packed {
    status_t             status;
    logic [BLKF_W-1:0]   block_out;
    logic                block_valid;
    logic [ID_W-1:0]     waiter_out;
    logic [CNT_W-1:0]    used_count;
    logic [CNT_W-1:0]    high_water;
    logic [GRANT_W-1:0]  grant_count;
  } out_res_t;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_RD,
    S_SCAN,
    S_RESP
  } ctl_state_t;

  // datapath actions
  typedef enum logic [3:0] {
    DP_NOP,
    DP_RD_LINK,
    DP_POP,
    DP_REJECT,
    DP_QFULL,
    DP_FREE,
    DP_SCAN_CLR,
    DP_SCAN_NEXT,
    DP_INSERT,
    DP_REMOVE,
    DP_NOTWAIT,
    DP_INIT
  } dp_op_t;

  typedef struct packed {
    logic   load;
    logic   emit;
    dp_op_t op;
  } cmd_t;

  typedef struct packed {
    func_t func;
    logic  free_avail;
    logic  wait_ok;
    logic  q_full;
    logic  blk_ok;
    logic  scan_end;
    logic  scan_hit;
    logic  out_free;
  } stat_t;

endpackage

// ===== rtl/core/fba_ram.sv =====
// fba_ram: generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module fba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/fba_ctrl.sv =====
// fba_ctrl: request sequencer of the block allocator
// depends on fba_pkg; drives fba_dp through cmd_t, watches stat_t
`timescale 1ns / 1ps

module fba_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  fba_pkg::stat_t stat,
  output fba_pkg::cmd_t  cmd
);

  import fba_pkg::*;

  ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        if (stat.func == FUNC_ALLOC && stat.free_avail) begin
          state_nxt = S_RD;
        end else if ((stat.func == FUNC_ALLOC && stat.wait_ok && !stat.q_full) ||
                     stat.func == FUNC_TIMEOUT) begin
          state_nxt = S_SCAN;
        end else begin
          state_nxt = S_RESP;
        end
      end
      S_RD: begin
        state_nxt = S_RESP;
      end
      S_SCAN: begin
        if (stat.scan_hit || stat.scan_end) state_nxt = S_RESP;
      end
      S_RESP: begin
        if (stat.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready = 1'b0;
    cmd.load = 1'b0;
    cmd.emit = 1'b0;
    cmd.op   = DP_NOP;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_DECODE: begin
        unique case (stat.func)
          FUNC_ALLOC: begin
            if (stat.free_avail)   cmd.op = DP_RD_LINK;
            else if (!stat.wait_ok) cmd.op = DP_REJECT;
            else if (stat.q_full)  cmd.op = DP_QFULL;
            else                   cmd.op = DP_SCAN_CLR;
          end
          FUNC_FREE:    cmd.op = stat.blk_ok ? DP_FREE : DP_REJECT;
          FUNC_TIMEOUT: cmd.op = DP_SCAN_CLR;
          FUNC_INIT:    cmd.op = DP_INIT;
          default:      cmd.op = DP_NOP;
        endcase
      end
      S_RD: begin
        cmd.op = DP_POP;
      end
      S_SCAN: begin
        if (stat.scan_hit || stat.scan_end) begin
          if (stat.func == FUNC_ALLOC) cmd.op = DP_INSERT;
          else if (stat.scan_hit)      cmd.op = DP_REMOVE;
          else                         cmd.op = DP_NOTWAIT;
        end else begin
          cmd.op = DP_SCAN_NEXT;
        end
      end
      S_RESP: begin
        cmd.emit = stat.out_free;
      end
      default: cmd.op = DP_NOP;
    endcase
  end

endmodule

// ===== rtl/core/fba_dp.sv =====
// fba_dp: free list, waiter queue, counters, config and result register
// depends on fba_pkg and fba_ram; commanded by fba_ctrl
`timescale 1ns / 1ps

module fba_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_valid,
  input  logic [fba_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fba_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  fba_pkg::in_req_t                   in_data,
  input  fba_pkg::cmd_t                      cmd,
  output fba_pkg::stat_t                     stat,
  output logic                               out_valid,
  input  logic                               out_ready,
  output fba_pkg::out_res_t                  out_data
);

  import fba_pkg::*;

  // config
  logic [CFG_DATA_W-1:0] block_count_r, block_count_nxt;
  logic                  monitor_r, monitor_nxt;

  // pool state
  logic [BLK_W-1:0]   free_head_r, free_head_nxt;
  logic [CNT_W-1:0]   free_fill_r, free_fill_nxt;
  logic [CNT_W-1:0]   pool_size_r, pool_size_nxt;
  logic [CNT_W-1:0]   in_use_r, in_use_nxt;
  logic [CNT_W-1:0]   peak_r, peak_nxt;
  logic [GRANT_W-1:0] grants_r, grants_nxt;
  logic [NBLOCKS-1:0] lvalid_r, lvalid_nxt;

  // waiter queue
  logic [ID_W-1:0]      wid_r [WAITERS];
  logic [ID_W-1:0]      wid_nxt [WAITERS];
  logic [PRIO_BITS-1:0] wpr_r [WAITERS];
  logic [PRIO_BITS-1:0] wpr_nxt [WAITERS];
  logic [WCNT_W-1:0]    fill_r, fill_nxt;
  logic [WCNT_W-1:0]    idx_r, idx_nxt;

  // working registers
  in_req_t          req_r, req_nxt;
  logic             lv_r, lv_nxt;
  logic [BLK_W-1:0] dflt_r, dflt_nxt;
  status_t          res_status_r, res_status_nxt;
  logic [BLK_W-1:0] res_bout_r, res_bout_nxt;
  logic             res_bvalid_r, res_bvalid_nxt;
  logic [ID_W-1:0]  res_wout_r, res_wout_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_res_t         out_data_r, out_data_nxt;

  // helpers
  logic                 ram_we;
  logic [BLK_W-1:0]     ram_rdata;
  logic [CNT_W-1:0]     n_clamp;
  logic [CNT_W-1:0]     in_use_inc;
  logic [PRIO_BITS-1:0] prio;
  logic [WIDX_W-1:0]    idx_e;
  logic                 ins_en;
  logic                 rm_en;
  logic [WCNT_W-1:0]    rm_pos;

  // next-link table; entries without a valid bit read as index minus one, entry zero as zero
  fba_ram #(
    .WIDTH (BLK_W),
    .DEPTH (NBLOCKS)
  ) u_link (
    .clk   (clk),
    .we    (ram_we),
    .waddr (req_r.block),
    .wdata (free_head_r),
    .raddr (free_head_r),
    .rdata (ram_rdata)
  );

  assign prio  = req_r.priority_req[PRIO_BITS-1:0];
  assign idx_e = idx_r[WIDX_W-1:0];

  assign n_clamp = (block_count_r == '0) ? CNT_W'(1) :
                   (block_count_r > CNT_W'(NBLOCKS)) ? CNT_W'(NBLOCKS) : block_count_r;

  assign in_use_inc = (in_use_r < CNT_W'(NBLOCKS)) ? in_use_r + CNT_W'(1) : in_use_r;

  // status to the controller
  always_comb begin
    stat.func       = req_r.func;
    stat.free_avail = (free_fill_r != '0);
    stat.wait_ok    = req_r.wait_allowed;
    stat.q_full     = (fill_r >= WCNT_W'(WAITERS));
    stat.blk_ok     = (CNT_W'(req_r.block) < pool_size_r);
    stat.scan_end   = (idx_r == fill_r);
    if (req_r.func == FUNC_ALLOC) begin
      stat.scan_hit = !stat.scan_end && (wpr_r[idx_e] > prio);
    end else begin
      stat.scan_hit = !stat.scan_end && (wid_r[idx_e] == req_r.requester);
    end
    stat.out_free   = !out_valid_r || out_ready;
  end

  always_comb begin
    block_count_nxt = block_count_r;
    monitor_nxt     = monitor_r;
    free_head_nxt   = free_head_r;
    free_fill_nxt   = free_fill_r;
    pool_size_nxt   = pool_size_r;
    in_use_nxt      = in_use_r;
    peak_nxt        = peak_r;
    grants_nxt      = grants_r;
    lvalid_nxt      = lvalid_r;
    wid_nxt         = wid_r;
    wpr_nxt         = wpr_r;
    fill_nxt        = fill_r;
    idx_nxt         = idx_r;
    req_nxt         = req_r;
    lv_nxt          = lv_r;
    dflt_nxt        = dflt_r;
    res_status_nxt  = res_status_r;
    res_bout_nxt    = res_bout_r;
    res_bvalid_nxt  = res_bvalid_r;
    res_wout_nxt    = res_wout_r;
    out_valid_nxt   = out_valid_r;
    out_data_nxt    = out_data_r;
    ram_we          = 1'b0;
    ins_en          = 1'b0;
    rm_en           = 1'b0;
    rm_pos          = '0;

    if (cfg_valid) begin
      case (cfg_index)
        CFG_BLOCK_COUNT:    block_count_nxt = cfg_data;
        CFG_MONITOR_ENABLE: monitor_nxt     = cfg_data[0];
        default: ;
      endcase
    end

    if (cmd.load) req_nxt = in_data;

    case (cmd.op)
      DP_RD_LINK: begin
        lv_nxt   = lvalid_r[free_head_r];
        dflt_nxt = (free_head_r == '0) ? '0 : free_head_r - BLK_W'(1);
      end
      DP_POP: begin
        res_status_nxt = ST_OK;
        res_bout_nxt   = free_head_r;
        res_bvalid_nxt = 1'b1;
        res_wout_nxt   = req_r.requester;
        free_head_nxt  = lv_r ? ram_rdata : dflt_r;
        free_fill_nxt  = free_fill_r - CNT_W'(1);
        in_use_nxt     = in_use_inc;
        if (monitor_r) begin
          grants_nxt = grants_r + GRANT_W'(1);
          if (peak_r < in_use_inc) peak_nxt = in_use_inc;
        end
      end
      DP_REJECT: begin
        res_status_nxt = ST_FAIL;
        res_bout_nxt   = '0;
        res_bvalid_nxt = 1'b0;
        res_wout_nxt   = (req_r.func == FUNC_ALLOC) ? req_r.requester : '0;
      end
      DP_QFULL: begin
        res_status_nxt = ST_QFULL;
        res_bout_nxt   = '0;
        res_bvalid_nxt = 1'b0;
        res_wout_nxt   = req_r.requester;
      end
      DP_FREE: begin
        ram_we                   = 1'b1;
        lvalid_nxt[req_r.block]  = 1'b1;
        if (fill_r != '0) begin
          // head waiter takes the block directly
          res_status_nxt = ST_HANDED;
          res_bout_nxt   = req_r.block;
          res_bvalid_nxt = 1'b1;
          res_wout_nxt   = wid_r[0];
          rm_en          = 1'b1;
          rm_pos         = '0;
          if (monitor_r) grants_nxt = grants_r + GRANT_W'(1);
        end else begin
          res_status_nxt = ST_FREED;
          res_bout_nxt   = '0;
          res_bvalid_nxt = 1'b0;
          res_wout_nxt   = '0;
          free_head_nxt  = req_r.block;
          if (free_fill_r < pool_size_r) free_fill_nxt = free_fill_r + CNT_W'(1);
          if (in_use_r != '0) in_use_nxt = in_use_r - CNT_W'(1);
        end
      end
      DP_SCAN_CLR: begin
        idx_nxt = '0;
      end
      DP_SCAN_NEXT: begin
        idx_nxt = idx_r + WCNT_W'(1);
      end
      DP_INSERT: begin
        res_status_nxt = ST_QUEUED;
        res_bout_nxt   = '0;
        res_bvalid_nxt = 1'b0;
        res_wout_nxt   = req_r.requester;
        ins_en         = 1'b1;
        fill_nxt       = fill_r + WCNT_W'(1);
      end
      DP_REMOVE: begin
        res_status_nxt = ST_TIMEOUT;
        res_bout_nxt   = '0;
        res_bvalid_nxt = 1'b0;
        res_wout_nxt   = req_r.requester;
        rm_en          = 1'b1;
        rm_pos         = idx_r;
      end
      DP_NOTWAIT: begin
        res_status_nxt = ST_NOTWAIT;
        res_bout_nxt   = '0;
        res_bvalid_nxt = 1'b0;
        res_wout_nxt   = req_r.requester;
      end
      DP_INIT: begin
        res_status_nxt = ST_OK;
        res_bout_nxt   = '0;
        res_bvalid_nxt = 1'b0;
        res_wout_nxt   = '0;
        pool_size_nxt  = n_clamp;
        free_head_nxt  = BLK_W'(n_clamp - CNT_W'(1));
        free_fill_nxt  = n_clamp;
        in_use_nxt     = '0;
        peak_nxt       = '0;
        grants_nxt     = '0;
        fill_nxt       = '0;
        lvalid_nxt     = '0;
      end
      default: ;
    endcase

    // priority insert: open a slot at the scan position
    if (ins_en) begin
      for (int j = 1; j < WAITERS; j++) begin
        if (WCNT_W'(j) > idx_r && WCNT_W'(j) <= fill_r) begin
          wid_nxt[j] = wid_r[j-1];
          wpr_nxt[j] = wpr_r[j-1];
        end
      end
      wid_nxt[idx_e] = req_r.requester;
      wpr_nxt[idx_e] = prio;
    end

    // removal: close the gap at rm_pos
    if (rm_en) begin
      for (int j = 0; j < WAITERS - 1; j++) begin
        if (WCNT_W'(j) >= rm_pos && WCNT_W'(j + 1) < fill_r) begin
          wid_nxt[j] = wid_r[j+1];
          wpr_nxt[j] = wpr_r[j+1];
        end
      end
      fill_nxt = fill_r - WCNT_W'(1);
    end

    // result register
    if (cmd.emit) begin
      out_valid_nxt            = 1'b1;
      out_data_nxt.status      = res_status_r;
      out_data_nxt.block_out   = res_bout_r;
      out_data_nxt.block_valid = res_bvalid_r;
      out_data_nxt.waiter_out  = res_wout_r;
      out_data_nxt.used_count  = in_use_r;
      out_data_nxt.high_water  = peak_r;
      out_data_nxt.grant_count = grants_r;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_count_r <= BLOCK_COUNT_RST;
      monitor_r     <= 1'b1;
      pool_size_r   <= CNT_W'(NBLOCKS);
      free_head_r   <= BLK_W'(NBLOCKS - 1);
      free_fill_r   <= CNT_W'(NBLOCKS);
      in_use_r      <= '0;
      peak_r        <= '0;
      grants_r      <= '0;
      lvalid_r      <= '0;
      fill_r        <= '0;
      idx_r         <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      block_count_r <= block_count_nxt;
      monitor_r     <= monitor_nxt;
      pool_size_r   <= pool_size_nxt;
      free_head_r   <= free_head_nxt;
      free_fill_r   <= free_fill_nxt;
      in_use_r      <= in_use_nxt;
      peak_r        <= peak_nxt;
      grants_r      <= grants_nxt;
      lvalid_r      <= lvalid_nxt;
      fill_r        <= fill_nxt;
      idx_r         <= idx_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wid_r        <= wid_nxt;
    wpr_r        <= wpr_nxt;
    req_r        <= req_nxt;
    lv_r         <= lv_nxt;
    dflt_r       <= dflt_nxt;
    res_status_r <= res_status_nxt;
    res_bout_r   <= res_bout_nxt;
    res_bvalid_r <= res_bvalid_nxt;
    res_wout_r   <= res_wout_nxt;
    out_data_r   <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/core/fixed_block_allocator_with_waiters.sv =====
// top level of the fixed block allocator with a priority waiter queue; depends on fba_pkg,
// fba_ctrl and fba_dp (which holds the fba_ram link table)
// steps from accept: decode, then the result state for free, init, fail and queue-full; a
//   granted alloc adds a link read; a queued alloc or a timeout scans the waiter entries in
//   order until its slot or its id is found or the queue ends, then waits in the result state
// one request in flight; the next can be taken in the cycle after the result loads; reset
// (synchronous, rst_n low) equals an init with block_count 64, monitor on
`timescale 1ns / 1ps

module fixed_block_allocator_with_waiters (
  input  logic                           clk,
  input  logic                           rst_n,
  // request channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  fba_pkg::in_req_t               in_data,
  // result channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output fba_pkg::out_res_t              out_data,
  // configuration writes
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [fba_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fba_pkg::CFG_DATA_W-1:0] cfg_data
);

  import fba_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // registers take a write in any cycle
  assign cfg_ready = 1'b1;

  // sequencer: decode, link read, waiter scan, result hand-off
  fba_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath: free list, waiter queue, counters and the result register,
  // which lets a new request in while the last result still waits
  fba_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== rtl/core/fba_checker.sv =====
// fba_checker: port-level assertions for the block allocator, bound to the top
// depends on fba_pkg and fixed_block_allocator_with_waiters
`timescale 1ns / 1ps

module fba_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input fba_pkg::in_req_t               in_data,
  input logic                           out_valid,
  input logic                           out_ready,
  input fba_pkg::out_res_t              out_data,
  input logic                           cfg_valid,
  input logic                           cfg_ready,
  input logic [fba_pkg::CFG_IDX_W-1:0]  cfg_index,
  input logic [fba_pkg::CFG_DATA_W-1:0] cfg_data
);

  import fba_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // one request at a time
  a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while another is in work");

  // a block only comes with a grant
  a_grant_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.block_valid |->
      (out_data.status == ST_OK || out_data.status == ST_HANDED))
    else $error("block_valid without a grant status");

  // statuses without a grant carry no block
  a_no_block: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == ST_FAIL || out_data.status == ST_QUEUED ||
                  out_data.status == ST_FREED || out_data.status == ST_TIMEOUT ||
                  out_data.status == ST_NOTWAIT || out_data.status == ST_QFULL) |->
      !out_data.block_valid && out_data.block_out == '0)
    else $error("block reported without a grant");

  // in-use count never exceeds the pool
  a_used_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.used_count <= CNT_W'(NBLOCKS))
    else $error("used_count beyond pool size");

endmodule

bind fixed_block_allocator_with_waiters fba_checker u_fba_checker (.*);

// ===== test/fba_pool_checker.sv =====
// fba_pool_checker: watches the request, result and register channels of the allocator,
// keeps its own free list and waiter queue, and counts mismatches
// depends on fba_pkg only
`timescale 1ns / 1ps

module fba_pool_checker
  import fba_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  in_req_t               in_data,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  out_res_t              out_data,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    mismatches,
  output int                    outstanding
);

  typedef struct packed {
    logic [ID_W-1:0]      id;
    logic [PRIO_IN_W-1:0] prio;
  } waiter_t;

  // register copies
  logic [CFG_DATA_W-1:0] reg_blocks;
  logic                  reg_monitor;

  // pool state
  logic [BLK_W-1:0]   link_of [NBLOCKS];
  int                 free_top;
  int                 free_len;
  int                 pool_len;
  int                 blocks_out;
  int                 peak_out;
  logic [GRANT_W-1:0] grant_total;
  waiter_t            waiting [$];

  out_res_t pending_results [$];
  int       error_total = 0;

  task automatic report(string what, longint got, longint want);
    if (error_total < 40) begin
      $display("%0t mismatch %s: got %0d, want %0d", $time, what, got, want);
    end
    error_total++;
  endtask

  function automatic void rebuild_pool();
    int n;
    int i;
    n = int'(reg_blocks);
    if (n < 1) n = 1;
    if (n > NBLOCKS) n = NBLOCKS;
    for (i = 0; i < NBLOCKS; i++) begin
      link_of[i] = BLK_W'(i == 0 ? 0 : i - 1);
    end
    pool_len    = n;
    free_top    = n - 1;
    free_len    = n;
    blocks_out  = 0;
    peak_out    = 0;
    grant_total = '0;
    waiting.delete();
  endfunction

  function automatic out_res_t serve_request(in_req_t r);
    out_res_t             res;
    logic [PRIO_IN_W-1:0] prio;
    waiter_t              w;
    int                   pos;
    int                   i;
    res = '0;
    res.status = ST_FAIL;
    prio = r.priority_req & PRIO_IN_W'((1 << PRIO_BITS) - 1);
    case (r.func)
      FUNC_ALLOC: begin
        res.waiter_out = r.requester;
        if (free_len > 0) begin
          res.status      = ST_OK;
          res.block_out   = BLKF_W'(free_top);
          res.block_valid = 1'b1;
          free_top = int'(link_of[free_top]);
          free_len--;
          if (blocks_out < NBLOCKS) blocks_out++;
          if (reg_monitor) begin
            grant_total++;
            if (peak_out < blocks_out) peak_out = blocks_out;
          end
        end else if (!r.wait_allowed) begin
          res.status = ST_FAIL;
        end else if (waiting.size() >= WAITERS) begin
          res.status = ST_QFULL;
        end else begin
          // goes behind every waiter of equal or better priority
          pos = waiting.size();
          for (i = 0; i < waiting.size(); i++) begin
            if (waiting[i].prio > prio) begin
              pos = i;
              break;
            end
          end
          w.id   = r.requester;
          w.prio = prio;
          waiting.insert(pos, w);
          res.status = ST_QUEUED;
        end
      end
      FUNC_FREE: begin
        if (int'(r.block) < pool_len) begin
          link_of[r.block] = BLK_W'(free_top);
          if (waiting.size() > 0) begin
            // straight to the head waiter, blocks in use unchanged
            w = waiting.pop_front();
            res.status      = ST_HANDED;
            res.waiter_out  = w.id;
            res.block_out   = r.block;
            res.block_valid = 1'b1;
            if (reg_monitor) grant_total++;
          end else begin
            free_top = int'(r.block);
            if (free_len < pool_len) free_len++;
            if (blocks_out > 0) blocks_out--;
            res.status = ST_FREED;
          end
        end
      end
      FUNC_TIMEOUT: begin
        res.waiter_out = r.requester;
        res.status     = ST_NOTWAIT;
        for (i = 0; i < waiting.size(); i++) begin
          if (waiting[i].id == r.requester) begin
            waiting.delete(i);
            res.status = ST_TIMEOUT;
            break;
          end
        end
      end
      FUNC_INIT: begin
        rebuild_pool();
        res.status = ST_OK;
      end
      default: ;
    endcase
    res.used_count  = CNT_W'(blocks_out);
    res.high_water  = CNT_W'(peak_out);
    res.grant_count = grant_total;
    return res;
  endfunction

  always @(posedge clk) begin : watch
    out_res_t want;
    if (!rst_n) begin
      reg_blocks  = BLOCK_COUNT_RST;
      reg_monitor = 1'b1;
      rebuild_pool();
      pending_results.delete();
    end else begin
      // results first, so a request taken on the same edge queues behind
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          report("result with no request outstanding", out_data.status, 0);
        end else begin
          want = pending_results.pop_front();
          if (out_data.status !== want.status)
            report("status", out_data.status, want.status);
          if (out_data.block_out !== want.block_out)
            report("block_out", out_data.block_out, want.block_out);
          if (out_data.block_valid !== want.block_valid)
            report("block_valid", out_data.block_valid, want.block_valid);
          if (out_data.waiter_out !== want.waiter_out)
            report("waiter_out", out_data.waiter_out, want.waiter_out);
          if (out_data.used_count !== want.used_count)
            report("used_count", out_data.used_count, want.used_count);
          if (out_data.high_water !== want.high_water)
            report("high_water", out_data.high_water, want.high_water);
          if (out_data.grant_count !== want.grant_count)
            report("grant_count", out_data.grant_count, want.grant_count);
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_BLOCK_COUNT) reg_blocks = cfg_data;
        else if (cfg_index == CFG_MONITOR_ENABLE) reg_monitor = cfg_data[0];
      end
      if (in_valid && in_ready) begin
        pending_results.push_back(serve_request(in_data));
      end
    end
    mismatches  <= error_total;
    outstanding <= pending_results.size();
  end

endmodule

// ===== test/tb_fixed_block_allocator_with_waiters.sv =====
// tb_fixed_block_allocator_with_waiters: clock, reset, stimulus and verdict for the allocator
// depends on fba_pkg, fixed_block_allocator_with_waiters and fba_pool_checker
`timescale 1ns / 1ps

module tb_fixed_block_allocator_with_waiters;
  import fba_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASES      = 20;
  localparam int PHASE_ITEMS = 90;
  localparam int SEGMENT     = 30;

  // request mixes of the random part
  typedef enum int {
    MIX_FILL,
    MIX_RELEASE,
    MIX_BLEND
  } mix_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  in_req_t               in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_res_t              out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    mismatches;
  int                    outstanding;

  logic [CFG_DATA_W-1:0] count_reg;  // block_count as last written
  int                    pool_now;   // pool size set up by the last init
  bit                    burst;      // no idling on either side while set
  bit                    hold_req;   // asks the receiver for its long hold-off
  int                    cycle_count;

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  fixed_block_allocator_with_waiters DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // checker sits beside the block on the same wires
  fba_pool_checker u_pool_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // idle length: mostly none or short, now and then long, none during a burst
  function automatic int idle_cycles();
    int roll;
    roll = $urandom_range(0, 99);
    if (burst || roll < 45) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic in_req_t pack_req(func_t f, int blk, int id, int prio, bit may_wait);
    in_req_t r;
    r.func         = f;
    r.block        = BLKF_W'(blk);
    r.requester    = ID_W'(id);
    r.priority_req = PRIO_IN_W'(prio);
    r.wait_allowed = may_wait;
    return r;
  endfunction

  // random request shaped by the current mix
  function automatic in_req_t make_request(mix_t mix);
    int    roll;
    int    alloc_cut;
    int    free_cut;
    int    timeout_cut;
    int    blk;
    int    prio;
    func_t f;
    case (mix)
      MIX_FILL: begin
        alloc_cut = 85; free_cut = 92; timeout_cut = 98;
      end
      MIX_RELEASE: begin
        alloc_cut = 15; free_cut = 85; timeout_cut = 98;
      end
      default: begin
        alloc_cut = 40; free_cut = 75; timeout_cut = 97;
      end
    endcase
    roll = $urandom_range(0, 99);
    if (roll < alloc_cut) f = FUNC_ALLOC;
    else if (roll < free_cut) f = FUNC_FREE;
    else if (roll < timeout_cut) f = FUNC_TIMEOUT;
    else f = FUNC_INIT;
    // frees mostly land inside the pool, the rest anywhere
    blk = ($urandom_range(0, 4) != 0) ? $urandom_range(0, pool_now - 1) : $urandom_range(0, 63);
    // a narrow priority range makes ties common
    prio = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 255) : $urandom_range(0, 3);
    return pack_req(f, blk, $urandom_range(0, 15), prio, $urandom_range(0, 9) != 0);
  endfunction

  // one request; valid stays high when the next request follows with no gap
  task automatic offer_request(in_req_t r);
    int gap;
    gap = idle_cycles();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    // track the pool size an init will build, for aiming frees
    if (r.func == FUNC_INIT) begin
      if (count_reg == 0) pool_now = 1;
      else if (count_reg > NBLOCKS) pool_now = NBLOCKS;
      else pool_now = int'(count_reg);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (!in_ready);
  endtask

  // writes both registers back to back, valid held across the pair
  task automatic write_pair(int blocks, bit monitor);
    count_reg = CFG_DATA_W'(blocks);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_BLOCK_COUNT;
    cfg_data  <= count_reg;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= CFG_MONITOR_ENABLE;
    cfg_data  <= CFG_DATA_W'(monitor);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // stop offering and wait for every outstanding result, then let the block go idle
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // result side: random stalls, runs of ready, and one long hold-off on request
  initial begin : sink
    int gap;
    int run;
    int k;
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        // request side keeps offering, so the block fills and stops taking requests
        hold_req = 1'b0;
        out_ready <= 1'b0;
        for (k = 0; k < HOLD_CYCLES; k++) @(posedge clk);
      end else begin
        gap = idle_cycles();
        if (gap > 0) begin
          out_ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        out_ready <= 1'b1;
        run = $urandom_range(1, 12);
        repeat (run) @(posedge clk);
      end
    end
  end

  // hang guard
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin : stimulus
    int   phase;
    int   k;
    int   blocks;
    mix_t mix;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_BLOCK_COUNT;
    cfg_data  <= '0;
    count_reg = BLOCK_COUNT_RST;
    pool_now  = NBLOCKS;
    burst     = 1'b0;
    hold_req  = 1'b0;
    mix       = MIX_BLEND;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // two-block pool: pops, failure, priority queueing, handoffs, timeouts
    write_pair(2, 1'b1);
    offer_request(pack_req(FUNC_INIT, 0, 0, 0, 1'b0));
    offer_request(pack_req(FUNC_ALLOC, 0, 0, 0, 1'b0));      // highest block first
    offer_request(pack_req(FUNC_ALLOC, 63, 15, 255, 1'b1));
    offer_request(pack_req(FUNC_ALLOC, 0, 1, 0, 1'b0));      // empty, may not wait
    offer_request(pack_req(FUNC_ALLOC, 0, 5, 200, 1'b1));    // queued
    offer_request(pack_req(FUNC_ALLOC, 0, 3, 200, 1'b1));    // equal priority, behind 5
    offer_request(pack_req(FUNC_ALLOC, 0, 9, 0, 1'b1));      // jumps to the head
    offer_request(pack_req(FUNC_ALLOC, 0, 5, 255, 1'b1));    // same id queued again
    offer_request(pack_req(FUNC_TIMEOUT, 0, 5, 0, 1'b0));    // first entry of id 5 goes
    offer_request(pack_req(FUNC_TIMEOUT, 0, 12, 0, 1'b0));   // id not waiting
    offer_request(pack_req(FUNC_FREE, 63, 0, 0, 1'b0));      // block beyond the pool
    offer_request(pack_req(FUNC_FREE, 1, 0, 0, 1'b0));       // handed to waiter 9
    offer_request(pack_req(FUNC_FREE, 0, 0, 0, 1'b0));       // handed to waiter 3
    offer_request(pack_req(FUNC_TIMEOUT, 0, 5, 0, 1'b0));
    offer_request(pack_req(FUNC_FREE, 1, 0, 0, 1'b0));
    offer_request(pack_req(FUNC_FREE, 1, 0, 0, 1'b0));
    offer_request(pack_req(FUNC_FREE, 0, 0, 0, 1'b0));       // free with the in-use count already at zero
    offer_request(pack_req(FUNC_ALLOC, 0, 2, 0, 1'b0));
    offer_request(pack_req(FUNC_ALLOC, 0, 4, 0, 1'b0));
    offer_request(pack_req(FUNC_ALLOC, 0, 7, 9, 1'b1));      // queued
    offer_request(pack_req(FUNC_INIT, 0, 0, 0, 1'b0));       // drops the waiter silently

    // block count below range, monitor off: grant and peak counters must hold
    settle();
    write_pair(0, 1'b0);
    offer_request(pack_req(FUNC_INIT, 0, 0, 0, 1'b0));
    offer_request(pack_req(FUNC_ALLOC, 0, 6, 0, 1'b0));
    offer_request(pack_req(FUNC_ALLOC, 0, 6, 0, 1'b0));
    offer_request(pack_req(FUNC_FREE, 0, 0, 0, 1'b0));

    // block count above range clamps to the full pool
    settle();
    write_pair(127, 1'b1);
    offer_request(pack_req(FUNC_INIT, 0, 0, 0, 1'b0));
    offer_request(pack_req(FUNC_ALLOC, 0, 15, 255, 1'b1));
    offer_request(pack_req(FUNC_FREE, 63, 0, 0, 1'b0));

    // random phases, each under its own register setting
    for (phase = 0; phase < PHASES; phase++) begin
      settle();
      case ($urandom_range(0, 9))
        0: blocks = NBLOCKS;
        1: blocks = ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(NBLOCKS + 1, 127);
        2: blocks = 1;
        default: blocks = $urandom_range(2, 8);
      endcase
      write_pair(blocks, $urandom_range(0, 3) != 0);
      if (phase == 2) hold_req = 1'b1;
      // without an init the old pool lives on under the new register value
      if ($urandom_range(0, 4) != 0) begin
        offer_request(pack_req(FUNC_INIT, $urandom_range(0, 63), $urandom_range(0, 15),
                               $urandom_range(0, 255), $urandom_range(0, 1) != 0));
      end
      for (k = 0; k < PHASE_ITEMS; k++) begin
        if (k % SEGMENT == 0) begin
          mix   = mix_t'($urandom_range(0, 2));
          burst = ($urandom_range(0, 3) == 0);
        end
        offer_request(make_request(mix));
      end
    end

    settle();
    burst = 1'b0;
    repeat (20) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/fba_pkg.sv
rtl/core/fba_ram.sv
rtl/core/fba_ctrl.sv
rtl/core/fba_dp.sv
rtl/core/fixed_block_allocator_with_waiters.sv
rtl/core/fba_checker.sv
test/fba_pool_checker.sv
test/tb_fixed_block_allocator_with_waiters.sv
